// File: sv/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types and constants for the DH forward kinematics chain.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_COUNT       = 24;
    localparam int WORK_BITS        = 30;

    localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COS_T,
        ST_COS_A,
        ST_DH,
        ST_MAC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [15:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } cordic_rsp_t;

    function automatic logic [33:0] atan_lut(input logic [4:0] i);
        logic [33:0] v;
        case (i)
            5'd0:  v = 34'd536870912;
            5'd1:  v = 34'd316933406;
            5'd2:  v = 34'd167458907;
            5'd3:  v = 34'd85004756;
            5'd4:  v = 34'd42667331;
            5'd5:  v = 34'd21354465;
            5'd6:  v = 34'd10680862;
            5'd7:  v = 34'd5340245;
            5'd8:  v = 34'd2670163;
            5'd9:  v = 34'd1335087;
            5'd10: v = 34'd667544;
            5'd11: v = 34'd333772;
            5'd12: v = 34'd166886;
            5'd13: v = 34'd83443;
            5'd14: v = 34'd41722;
            5'd15: v = 34'd20861;
            5'd16: v = 34'd10430;
            5'd17: v = 34'd5215;
            5'd18: v = 34'd2608;
            5'd19: v = 34'd1304;
            5'd20: v = 34'd652;
            5'd21: v = 34'd326;
            5'd22: v = 34'd163;
            5'd23: v = 34'd81;
            default: v = 34'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/dh_forward_kinematics_chain_core.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_core
// DH link matrix from CORDIC sin/cos, multiplied into an accumulated transform.
// ----------------------------------------------------------------------------
// channel | direction | tdata / tuser
// s_axis  | in        | tdata: link_length, link_twist, link_offset, joint_angle;
//         |           | tuser: first_link
// m_axis  | out       | tdata: rot_r0c0..rot_r2c2, pos_x, pos_y, pos_z
//
// Each item runs the iterative CORDIC twice (joint angle, then link twist),
// then six DH terms and 36 accumulate products on one shared multiplier,
// one per cycle.
// s_tready is high only while idle; a waiting result holds the block in its
// output state only when the next result is ready before the old one is taken.
// Reset loads identity into the accumulator.
module dh_forward_kinematics_chain_core #(
    parameter int FRAC_BITS    = dhfk_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] link_length, [47:32] link_twist, [79:48] link_offset,
    // [95:80] joint_angle
    input  logic [95:0]  s_tdata,
    // [0] first_link
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] rot_r0c0 ... [287:256] rot_r2c2, [319:288] pos_x,
    // [351:320] pos_y, [383:352] pos_z
    output logic [383:0] m_tdata
);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    dhfk_pkg::state_t state_reg, state_next;
    dhfk_pkg::cordic_req_t creq;
    dhfk_pkg::cordic_rsp_t crsp;

    logic signed [31:0] acc_reg [12];
    logic signed [31:0] dh_reg  [12];
    logic signed [31:0] nx_reg  [12];
    logic signed [31:0] a_reg, d_reg, ct_reg, st_reg, ca_reg, sa_reg;
    logic [15:0]        tw_reg, th_reg;
    logic               first_reg;
    logic               start_reg, start_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [1:0]         r_reg, r_next, j_reg, j_next, k_reg, k_next;
    logic               out_load;
    logic signed [35:0] sum_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [35:0] prod_r;
    logic [1:0]         r_i, j_i, k_i;
    logic [3:0]         a_idx, b_idx, n_idx;

    dhfk_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp)
    );

    // MAC walks row r, column j, term k
    always_comb begin
        r_i   = r_reg;
        j_i   = j_reg;
        k_i   = k_reg;
        a_idx = 4'({r_i, 2'b00}) + 4'(k_i);
        b_idx = 4'({k_i, 2'b00}) + 4'(j_i);
        n_idx = 4'({r_i, 2'b00}) + 4'(j_i);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = acc_reg[a_idx];
        mul_b = dh_reg[b_idx];
        if (state_reg == dhfk_pkg::ST_DH) begin
            case (cnt_reg)
                3'd0: begin mul_a = st_reg; mul_b = ca_reg; end
                3'd1: begin mul_a = st_reg; mul_b = sa_reg; end
                3'd2: begin mul_a = a_reg;  mul_b = ct_reg; end
                3'd3: begin mul_a = ct_reg; mul_b = ca_reg; end
                3'd4: begin mul_a = ct_reg; mul_b = sa_reg; end
                default: begin mul_a = a_reg; mul_b = st_reg; end
            endcase
        end
    end

    assign prod   = mul_a * mul_b;
    assign prod_r = 36'((prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

    // load the output register once the previous result is gone
    assign out_load = (state_reg == dhfk_pkg::ST_OUT) && (!m_tvalid || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        start_next = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            dhfk_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    start_next = 1'b1;
                    state_next = dhfk_pkg::ST_COS_T;
                end
            end
            dhfk_pkg::ST_COS_T: begin
                if (crsp.done) begin
                    start_next = 1'b1;
                    state_next = dhfk_pkg::ST_COS_A;
                end
            end
            dhfk_pkg::ST_COS_A: begin
                if (crsp.done) begin
                    cnt_next   = '0;
                    state_next = dhfk_pkg::ST_DH;
                end
            end
            dhfk_pkg::ST_DH: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    cnt_next   = '0;
                    r_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = dhfk_pkg::ST_MAC;
                end
            end
            dhfk_pkg::ST_MAC: begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2) begin
                    k_next = '0;
                    j_next = j_reg + 2'd1;
                    if (j_reg == 2'd3) begin
                        j_next = '0;
                        r_next = r_reg + 2'd1;
                        if (r_reg == 2'd2) begin
                            r_next     = '0;
                            state_next = dhfk_pkg::ST_OUT;
                        end
                    end
                end
            end
            dhfk_pkg::ST_OUT: begin
                if (!m_tvalid || m_tready) begin
                    state_next = dhfk_pkg::ST_IDLE;
                end
            end
            default: state_next = dhfk_pkg::ST_IDLE;
        endcase
    end

    assign creq.start = start_reg;
    assign creq.angle = (state_reg == dhfk_pkg::ST_COS_T) ? th_reg : tw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dhfk_pkg::ST_IDLE;
            cnt_reg   <= '0;
            r_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            start_reg <= 1'b0;
            m_tvalid  <= 1'b0;
            for (int i = 0; i < 12; i++) begin
                acc_reg[i] <= (i % 5 == 0) ? ONE : 32'sd0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            r_reg     <= r_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            start_reg <= start_next;
            if (out_load) begin
                m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
            if (state_reg == dhfk_pkg::ST_DH && cnt_reg == 3'd0 && first_reg) begin
                for (int i = 0; i < 12; i++) begin
                    acc_reg[i] <= (i % 5 == 0) ? ONE : 32'sd0;
                end
            end
            if (out_load) begin
                for (int i = 0; i < 12; i++) begin
                    acc_reg[i] <= nx_reg[i];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == dhfk_pkg::ST_IDLE && s_tvalid) begin
            a_reg     <= s_tdata[31:0];
            tw_reg    <= s_tdata[47:32];
            d_reg     <= s_tdata[79:48];
            th_reg    <= s_tdata[95:80];
            first_reg <= s_tuser;
        end
        if (state_reg == dhfk_pkg::ST_COS_T && crsp.done) begin
            ct_reg <= crsp.cos_v;
            st_reg <= crsp.sin_v;
        end
        if (state_reg == dhfk_pkg::ST_COS_A && crsp.done) begin
            ca_reg    <= crsp.cos_v;
            sa_reg    <= crsp.sin_v;
            dh_reg[0] <= dhfk_pkg::sat32(36'(ct_reg));
            dh_reg[4] <= dhfk_pkg::sat32(36'(st_reg));
            dh_reg[8] <= '0;
            dh_reg[9] <= dhfk_pkg::sat32(36'(crsp.sin_v));
            dh_reg[10] <= dhfk_pkg::sat32(36'(crsp.cos_v));
            dh_reg[11] <= d_reg;
        end
        if (state_reg == dhfk_pkg::ST_DH) begin
            case (cnt_reg)
                3'd0: dh_reg[1] <= dhfk_pkg::sat32(-prod_r);
                3'd1: dh_reg[2] <= dhfk_pkg::sat32(prod_r);
                3'd2: dh_reg[3] <= dhfk_pkg::sat32(prod_r);
                3'd3: dh_reg[5] <= dhfk_pkg::sat32(prod_r);
                3'd4: dh_reg[6] <= dhfk_pkg::sat32(-prod_r);
                default: dh_reg[7] <= dhfk_pkg::sat32(prod_r);
            endcase
        end
        if (state_reg == dhfk_pkg::ST_MAC) begin
            // add the old position in on the first product of the last column
            if (k_i == 2'd0) begin
                sum_reg <= prod_r + ((j_i == 2'd3) ? 36'(acc_reg[n_idx]) : 36'sd0);
            end else begin
                sum_reg <= sum_reg + prod_r;
            end
            if (k_i == 2'd2) begin
                nx_reg[n_idx] <= dhfk_pkg::sat32(sum_reg + prod_r);
            end
        end
        if (out_load) begin
            m_tdata <= {nx_reg[11], nx_reg[7], nx_reg[3],
                        nx_reg[10], nx_reg[9], nx_reg[8],
                        nx_reg[6],  nx_reg[5], nx_reg[4],
                        nx_reg[2],  nx_reg[1], nx_reg[0]};
        end
    end
endmodule

// File: sv/dhfk_cordic.sv
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative CORDIC rotation: one micro-rotation per cycle, gives cos and sin.
// ----------------------------------------------------------------------------
module dhfk_cordic #(
    parameter int FRAC_BITS    = dhfk_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dhfk_pkg::cordic_req_t req,
    output dhfk_pkg::cordic_rsp_t rsp
);
    localparam int STEPS = (CORDIC_STEPS < dhfk_pkg::ATAN_COUNT) ?
                           CORDIC_STEPS : dhfk_pkg::ATAN_COUNT;
    localparam int SH = dhfk_pkg::WORK_BITS - FRAC_BITS;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               flip_reg, flip_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         step_reg, step_next;
    logic signed [33:0] zi, xo, yo;
    logic signed [34:0] xr, yr;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        zi        = {{2{req.angle[15]}}, req.angle, 16'd0};
        if (req.start) begin
            // fold into the right half plane and flip the result
            flip_next = (zi > dhfk_pkg::QUARTER_TURN) || (zi < -dhfk_pkg::QUARTER_TURN);
            if (zi > dhfk_pkg::QUARTER_TURN) begin
                z_next = zi - (dhfk_pkg::QUARTER_TURN <<< 1);
            end else if (zi < -dhfk_pkg::QUARTER_TURN) begin
                z_next = zi + (dhfk_pkg::QUARTER_TURN <<< 1);
            end else begin
                z_next = zi;
            end
            x_next    = dhfk_pkg::GAIN_Q30;
            y_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - (y_reg >>> step_reg);
                y_next = y_reg + (x_reg >>> step_reg);
                z_next = z_reg - $signed(dhfk_pkg::atan_lut(step_reg));
            end else begin
                x_next = x_reg + (y_reg >>> step_reg);
                y_next = y_reg - (x_reg >>> step_reg);
                z_next = z_reg + $signed(dhfk_pkg::atan_lut(step_reg));
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(STEPS - 1)) begin
                // last micro-rotation lands this edge; flag it for one cycle
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign xo = flip_reg ? -x_reg : x_reg;
    assign yo = flip_reg ? -y_reg : y_reg;
    assign xr = (35'(xo) + (35'sd1 <<< (SH - 1))) >>> SH;
    assign yr = (35'(yo) + (35'sd1 <<< (SH - 1))) >>> SH;

    assign rsp.done  = done_reg;
    assign rsp.cos_v = xr[31:0];
    assign rsp.sin_v = yr[31:0];
endmodule

// File: sv/dhfk_checker.sv
// ----------------------------------------------------------------------------
// dhfk_port_props
// Port-level checks for the DH forward kinematics chain.
// ----------------------------------------------------------------------------
module dhfk_port_props (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_known_handshake: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tready, m_tvalid}))
        else $error("handshake output unknown");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("ready during item work");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result without work");
endmodule

bind dh_forward_kinematics_chain_core dhfk_port_props u_dhfk_port_props (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: dv/dhfk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhfk_checker
// Watches both channels of the DH chain core, predicts the accumulated
// transform for every accepted link item and compares each result item.
// ----------------------------------------------------------------------------
module dhfk_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [383:0] m_tdata,
    output int           fail_count,
    output int           pending_count
);
    localparam int FRAC = dhfk_pkg::FRAC_BITS_DEF;
    localparam int STEPS = dhfk_pkg::CORDIC_STEPS_DEF;

    longint chain_xform[12];
    logic [383:0] pose_queue[$];

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint p, longint q);
        return fshift(p * q + (64'sd1 <<< (FRAC - 1)), FRAC);
    endfunction

    task automatic cordic_sc(input logic [15:0] ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        logic flip;
        int lim;
        z = longint'($signed({ang, 16'h0000}));
        flip = 0;
        x = longint'(dhfk_pkg::GAIN_Q30);
        y = 0;
        if (z > longint'(dhfk_pkg::QUARTER_TURN) || z < -longint'(dhfk_pkg::QUARTER_TURN)) begin
            z = (z > 0) ? z - 2 * longint'(dhfk_pkg::QUARTER_TURN)
                        : z + 2 * longint'(dhfk_pkg::QUARTER_TURN);
            flip = 1;
        end
        lim = (STEPS < 24) ? STEPS : 24;
        for (int i = 0; i < lim; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(dhfk_pkg::atan_lut(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(dhfk_pkg::atan_lut(5'(i)));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = fshift(x + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
        s = fshift(y + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
    endtask

    task automatic load_identity();
        for (int i = 0; i < 12; i++) chain_xform[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC) : 0;
    endtask

    task automatic advance_chain(input logic [95:0] d, input logic first);
        longint a, off, ct, st, ca, sa, sum;
        longint link[12];
        longint nxt[12];
        logic [383:0] pose;
        a = longint'($signed(d[31:0]));
        off = longint'($signed(d[79:48]));
        cordic_sc(d[95:80], ct, st);
        cordic_sc(d[47:32], ca, sa);
        link[0] = clamp32(ct);
        link[1] = clamp32(-qmul(st, ca));
        link[2] = clamp32(qmul(st, sa));
        link[3] = clamp32(qmul(a, ct));
        link[4] = clamp32(st);
        link[5] = clamp32(qmul(ct, ca));
        link[6] = clamp32(-qmul(ct, sa));
        link[7] = clamp32(qmul(a, st));
        link[8] = 0;
        link[9] = clamp32(sa);
        link[10] = clamp32(ca);
        link[11] = off;
        if (first) load_identity();
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 4; j++) begin
                sum = (j == 3) ? chain_xform[r * 4 + 3] : 0;
                for (int k = 0; k < 3; k++) sum += qmul(chain_xform[r * 4 + k], link[k * 4 + j]);
                nxt[r * 4 + j] = clamp32(sum);
            end
        end
        for (int k = 0; k < 12; k++) chain_xform[k] = nxt[k];
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) pose[(r * 3 + j) * 32 +: 32] = chain_xform[r * 4 + j][31:0];
            pose[(9 + r) * 32 +: 32] = chain_xform[r * 4 + 3][31:0];
        end
        pose_queue.push_back(pose);
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
        load_identity();
    end

    always @(posedge aclk) begin
        logic [383:0] want;
        if (aresetn && s_tvalid && s_tready) advance_chain(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready) begin
            if (pose_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result item %h", m_tdata);
            end else begin
                want = pose_queue.pop_front();
                for (int f = 0; f < 12; f++) begin
                    if (m_tdata[f * 32 +: 32] !== want[f * 32 +: 32]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("field %0d: expected %h, got %h", f,
                                     want[f * 32 +: 32], m_tdata[f * 32 +: 32]);
                    end
                end
            end
        end
        pending_count = pose_queue.size();
    end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives DH link items into the chain core with random gaps and stalls;
// the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
    logic aclk, aresetn, s_tvalid, s_tready, s_tuser, m_tvalid, m_tready;
    logic [95:0] s_tdata;
    logic [383:0] m_tdata;
    int fail_count, pending_count;
    int send_idle, recv_idle, quiet_cycles;
    logic timed_out;

    dh_forward_kinematics_chain_core DUT (.*);

    dhfk_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver stalls
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    // watchdog on cycles with no accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !timed_out) begin
            timed_out = 1;
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'(16'h4000 + $urandom_range(2) - 1);
            2: return 16'(16'hC000 + $urandom_range(2) - 1);
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_q(logic wide);
        if (wide) return $urandom;
        return $signed($urandom_range(32'h00100000)) - 32'sh00080000;
    endfunction

    // hold the item until s_tready is seen mid-cycle, then let the edge take it
    task automatic send_link(input logic [31:0] a, input logic [15:0] tw,
                             input logic [31:0] d, input logic [15:0] th, input logic first);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {th, d, tw, a};
        s_tuser <= first;
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [15:0] angles[8];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF, 16'h4001, 16'h2000};
        timed_out = 0;
        quiet_cycles = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        m_tready = 0;
        send_idle = 37;
        recv_idle = 76;
        repeat (9) @(negedge aclk);
        aresetn = 1;
        // directed: angle corners, length/offset extremes, restart flag
        for (int i = 0; i < 8; i++) send_link(32'h00010000, angles[i], 32'h00020000,
                                               angles[7 - i], i == 0);
        send_link(32'h7FFFFFFF, 16'h0000, 32'h80000000, 16'h0000, 1);
        send_link(32'h80000000, 16'h8000, 32'h7FFFFFFF, 16'h8000, 0);
        send_link(32'h7FFFFFFF, 16'h2000, 32'h7FFFFFFF, 16'h2000, 0);
        send_link(32'h80000000, 16'hFFFF, 32'h80000000, 16'hFFFF, 0);
        send_link(32'h00000000, 16'h1234, 32'h00000000, 16'hABCD, 1);
        send_link(32'hFFFFFFFF, 16'h5555, 32'h00000001, 16'hAAAA, 0);
        for (int n = 0; n < 836; n++) begin
            if (n == 280) begin
                send_idle = 76;
                recv_idle = 37;
            end
            if (n == 560) begin
                // hold until the block is drained
                s_tvalid <= 0;
                while (pending_count != 0) @(negedge aclk);
                @(negedge aclk);
                send_idle = 0;
                recv_idle = 0;
            end
            send_link(pick_q($urandom_range(9) == 0), pick_angle(),
                      pick_q($urandom_range(9) == 0), pick_angle(), $urandom_range(5) == 0);
        end
        s_tvalid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
